// ----- rtl/lpi_pkg.sv -----
`default_nettype none
package lpi_pkg;

    localparam int OUT_BITS = 24;
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF = 8;

    // per-item control that rides alongside the divider lanes
    typedef struct packed {
        logic ok;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } lpi_meta_t;

endpackage
`default_nettype wire

// ----- rtl/lpi_div_lane.sv -----
`default_nettype none
module lpi_div_lane #(
    parameter int W = 64
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [W-1:0]                 num,
    input  wire logic [W-1:0]                 den,
    output logic      [lpi_pkg::OUT_BITS-1:0] quo
);
    import lpi_pkg::*;

    localparam int QB = OUT_BITS;

    logic [W-1:0]  rem_reg [QB];
    logic [W-1:0]  den_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [W-1:0]  den_in;
        logic [QB-1:0] quo_in;
        logic [W-1:0]  sub;
        logic [W-1:0]  rem_next;
        logic [QB-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign sub = den_in << (QB - 1 - k);

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= sub)
            begin
                rem_next = rem_in - sub;
                quo_next[QB-1-k] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule
`default_nettype wire

// ----- rtl/line_pair_intersection.sv -----
`default_nettype none
// Line pair intersection: each request carries two segments; the block returns
// the intersection in signed fixed point (FRAC_BITS fraction bits, truncated
// toward zero, saturated to 24 bits with clipped set), or hit_valid = 0 and
// -1.0 for parallel pairs and pairs meeting below 45 degrees. Fully pipelined:
// one request per cycle while the output is not stalled, through the front stages,
// the 24-stage restoring divider (one quotient bit per stage) on each coordinate
// and the final output register. A stall on the output freezes the whole pipe.
module line_pair_intersection #(
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [COORD_BITS-1:0]               first_start_x,
    input  wire logic [COORD_BITS-1:0]               first_start_y,
    input  wire logic [COORD_BITS-1:0]               first_end_x,
    input  wire logic [COORD_BITS-1:0]               first_end_y,
    input  wire logic [COORD_BITS-1:0]               second_start_x,
    input  wire logic [COORD_BITS-1:0]               second_start_y,
    input  wire logic [COORD_BITS-1:0]               second_end_x,
    input  wire logic [COORD_BITS-1:0]               second_end_y,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     hit_valid,
    output logic signed [lpi_pkg::OUT_BITS-1:0]      cross_x,
    output logic signed [lpi_pkg::OUT_BITS-1:0]      cross_y,
    output logic                                     clipped
);
    import lpi_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int D   = C + 1;
    localparam int DW  = 2 * D + 1;
    localparam int CW  = 2 * C + 1;
    localparam int TW  = CW + D;
    localparam int NW  = TW + 1;
    localparam int NMW = NW + FRAC_BITS;
    localparam int W   = (NMW > DW + OUT_BITS) ? NMW : DW + OUT_BITS;
    localparam int S   = OUT_BITS;

    localparam logic [OUT_BITS-1:0] POS_LIM = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] NEG_LIM = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam logic [OUT_BITS-1:0] INVALID =
        OUT_BITS'(-(64'sd1 <<< FRAC_BITS));

    logic en;
    logic out_valid_reg;

    assign en = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: differences and cross-term products of the end points
    logic v1_reg;
    logic signed [D-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic [2*C-1:0] pa_reg, pb_reg, pc_reg, pd_reg;

    // stage 2
    logic v2_reg;
    logic signed [2*D-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [CW-1:0] c1_reg, c2_reg;
    logic signed [D-1:0] dx1b_reg, dy1b_reg, dx2b_reg, dy2b_reg;

    // stage 3
    logic v3_reg;
    logic signed [DW-1:0] det_reg, dot_reg;
    logic signed [CW-1:0] c1b_reg, c2b_reg;
    logic signed [D-1:0] dx1c_reg, dy1c_reg, dx2c_reg, dy2c_reg;

    // stage 4
    logic v4_reg;
    logic signed [TW-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [DW-1:0] det4_reg;
    logic ok4_reg;

    // stage 5
    logic v5_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [DW-1:0] det5_reg;
    logic ok5_reg;

    // stage 6: magnitudes, signs and range pre-check
    logic v6_reg;
    logic [W-1:0] nmx_reg, nmy_reg, dm_reg;
    lpi_meta_t meta6_reg;

    logic [DW-1:0] det_mag3, dot_mag3, det_mag5;
    logic [NW-1:0] nx_mag, ny_mag;
    logic [W-1:0]  nmx_next, nmy_next, dm_next, dlim;

    assign det_mag3 = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
    assign dot_mag3 = dot_reg[DW-1] ? DW'(-dot_reg) : DW'(dot_reg);
    assign det_mag5 = det5_reg[DW-1] ? DW'(-det5_reg) : DW'(det5_reg);
    assign nx_mag   = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
    assign ny_mag   = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
    assign nmx_next = W'(nx_mag) << FRAC_BITS;
    assign nmy_next = W'(ny_mag) << FRAC_BITS;
    assign dm_next  = W'(det_mag5);
    assign dlim     = dm_next << OUT_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg <= $signed({1'b0, first_start_x}) - $signed({1'b0, first_end_x});
            dy1_reg <= $signed({1'b0, first_start_y}) - $signed({1'b0, first_end_y});
            dx2_reg <= $signed({1'b0, second_start_x}) - $signed({1'b0, second_end_x});
            dy2_reg <= $signed({1'b0, second_start_y}) - $signed({1'b0, second_end_y});
            pa_reg  <= first_start_x * first_end_y;
            pb_reg  <= first_start_y * first_end_x;
            pc_reg  <= second_start_x * second_end_y;
            pd_reg  <= second_start_y * second_end_x;

            m1_reg   <= dx1_reg * dy2_reg;
            m2_reg   <= dy1_reg * dx2_reg;
            m3_reg   <= dy1_reg * dy2_reg;
            m4_reg   <= dx1_reg * dx2_reg;
            c1_reg   <= $signed({1'b0, pa_reg}) - $signed({1'b0, pb_reg});
            c2_reg   <= $signed({1'b0, pc_reg}) - $signed({1'b0, pd_reg});
            dx1b_reg <= dx1_reg;
            dy1b_reg <= dy1_reg;
            dx2b_reg <= dx2_reg;
            dy2b_reg <= dy2_reg;

            det_reg  <= DW'(m1_reg) - DW'(m2_reg);
            dot_reg  <= DW'(m3_reg) + DW'(m4_reg);
            c1b_reg  <= c1_reg;
            c2b_reg  <= c2_reg;
            dx1c_reg <= dx1b_reg;
            dy1c_reg <= dy1b_reg;
            dx2c_reg <= dx2b_reg;
            dy2c_reg <= dy2b_reg;

            t1_reg   <= c1b_reg * dx2c_reg;
            t2_reg   <= dx1c_reg * c2b_reg;
            t3_reg   <= c1b_reg * dy2c_reg;
            t4_reg   <= dy1c_reg * c2b_reg;
            det4_reg <= det_reg;
            ok4_reg  <= (det_mag3 != '0) && !(det_mag3 < dot_mag3);

            nx_reg   <= NW'(t1_reg) - NW'(t2_reg);
            ny_reg   <= NW'(t3_reg) - NW'(t4_reg);
            det5_reg <= det4_reg;
            ok5_reg  <= ok4_reg;

            nmx_reg         <= nmx_next;
            nmy_reg         <= nmy_next;
            dm_reg          <= dm_next;
            meta6_reg.ok    <= ok5_reg;
            meta6_reg.neg_x <= nx_reg[NW-1] != det5_reg[DW-1];
            meta6_reg.neg_y <= ny_reg[NW-1] != det5_reg[DW-1];
            // quotient at or past 2^OUT_BITS always saturates
            meta6_reg.ovf_x <= nmx_next >= dlim;
            meta6_reg.ovf_y <= nmy_next >= dlim;
        end
    end

    // divider lanes and the matching control shift line
    logic [OUT_BITS-1:0] qx, qy;
    logic      dv_reg   [S];
    lpi_meta_t dmeta_reg [S];

    lpi_div_lane #(.W(W)) u_div_x (
        .clk (clk),
        .en  (en),
        .num (nmx_reg),
        .den (dm_reg),
        .quo (qx)
    );

    lpi_div_lane #(.W(W)) u_div_y (
        .clk (clk),
        .en  (en),
        .num (nmy_reg),
        .den (dm_reg),
        .quo (qy)
    );

    for (genvar k = 0; k < S; k++) begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k] <= 1'b0;
            else if (en)
                dv_reg[k] <= (k == 0) ? v6_reg : dv_reg[(k == 0) ? 0 : k - 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dmeta_reg[k] <= (k == 0) ? meta6_reg : dmeta_reg[(k == 0) ? 0 : k - 1];
        end
    end

    // final stage: saturate, apply sign, pick the reject pattern
    lpi_meta_t           fm;
    logic [OUT_BITS-1:0] lim_x, lim_y, val_x, val_y, res_x, res_y;
    logic                clip_x, clip_y;

    logic                hit_reg, clip_reg;
    logic [OUT_BITS-1:0] cx_reg, cy_reg;

    assign fm     = dmeta_reg[S-1];
    assign lim_x  = fm.neg_x ? NEG_LIM : POS_LIM;
    assign lim_y  = fm.neg_y ? NEG_LIM : POS_LIM;
    assign clip_x = fm.ovf_x || (qx > lim_x);
    assign clip_y = fm.ovf_y || (qy > lim_y);
    assign val_x  = clip_x ? lim_x : qx;
    assign val_y  = clip_y ? lim_y : qy;
    assign res_x  = fm.neg_x ? OUT_BITS'(-val_x) : val_x;
    assign res_y  = fm.neg_y ? OUT_BITS'(-val_y) : val_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[S-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= fm.ok;
            cx_reg   <= fm.ok ? res_x : INVALID;
            cy_reg   <= fm.ok ? res_y : INVALID;
            clip_reg <= fm.ok && (clip_x || clip_y);
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_valid = hit_reg;
    assign cross_x   = $signed(cx_reg);
    assign cross_y   = $signed(cy_reg);
    assign clipped   = clip_reg;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none
module testbench;
    import lpi_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int RANDOM_REQUESTS = 1250;
    localparam int PIPE_LATENCY = 31;

    typedef logic [CB-1:0] coord_t;
    typedef logic signed [OUT_BITS-1:0] fix_t;

    typedef struct {
        logic hit;
        fix_t px;
        fix_t py;
        logic clip;
    } crossing_t;

    class crossing_board;
        crossing_t pending[$];
        int errors = 0;
        int hits = 0;
        int misses = 0;
        int clips = 0;

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        // scale num/den to fixed point, truncate toward zero, saturate
        function fix_t scale_div(longint num, longint den, ref logic clip);
            longint unsigned nm, dm, q, r, val, limit;
            logic neg;
            nm = magnitude(num);
            dm = magnitude(den);
            neg = (num < 0) != (den < 0);
            limit = neg ? (64'd1 << (OUT_BITS - 1)) : (64'd1 << (OUT_BITS - 1)) - 1;
            q = nm / dm;
            r = nm % dm;
            if (q > ((64'd1 << (OUT_BITS - 1)) >> FB)) begin
                val = limit;
                clip = 1'b1;
            end
            else begin
                val = (q << FB) + ((r << FB) / dm);
                if (val > limit) begin
                    val = limit;
                    clip = 1'b1;
                end
            end
            if (neg)
                return fix_t'(-longint'(val));
            return fix_t'(val);
        endfunction

        function void note_request(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                   coord_t cx, coord_t cy, coord_t ex, coord_t ey);
            longint x1, y1, x2, y2, x3, y3, x4, y4;
            longint dx1, dy1, dx2, dy2, det, dot, c1, c2;
            logic clip;
            crossing_t e;
            x1 = ax; y1 = ay; x2 = bx; y2 = by;
            x3 = cx; y3 = cy; x4 = ex; y4 = ey;
            dx1 = x1 - x2; dy1 = y1 - y2;
            dx2 = x3 - x4; dy2 = y3 - y4;
            det = dx1 * dy2 - dy1 * dx2;
            dot = dy1 * dy2 + dx1 * dx2;
            clip = 1'b0;
            if (det == 0 || magnitude(det) < magnitude(dot)) begin
                e.hit = 1'b0;
                e.px = fix_t'(-(longint'(1) << FB));
                e.py = e.px;
                misses++;
            end
            else begin
                c1 = x1 * y2 - y1 * x2;
                c2 = x3 * y4 - y3 * x4;
                e.hit = 1'b1;
                e.px = scale_div(c1 * dx2 - dx1 * c2, det, clip);
                e.py = scale_div(c1 * dy2 - dy1 * c2, det, clip);
                hits++;
                if (clip)
                    clips++;
            end
            e.clip = clip;
            pending = {pending, e};
        endfunction

        function void check_result(logic hit, fix_t px, fix_t py, logic clip);
            crossing_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result hit=%b x=%0d y=%0d clipped=%b",
                         $time, hit, px, py, clip);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (hit !== e.hit) begin
                $display("%0t: hit_valid expected %b actual %b", $time, e.hit, hit);
                errors++;
            end
            if (px !== e.px) begin
                $display("%0t: cross_x expected %0d actual %0d", $time, e.px, px);
                errors++;
            end
            if (py !== e.py) begin
                $display("%0t: cross_y expected %0d actual %0d", $time, e.py, py);
                errors++;
            end
            if (clip !== e.clip) begin
                $display("%0t: clipped expected %b actual %b", $time, e.clip, clip);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    coord_t first_start_x = '0, first_start_y = '0, first_end_x = '0, first_end_y = '0;
    coord_t second_start_x = '0, second_start_y = '0, second_end_x = '0, second_end_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit_valid;
    fix_t cross_x, cross_y;
    logic clipped;
    logic quiet = 1'b0;
    crossing_board board = new();

    line_pair_intersection i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .first_start_x(first_start_x), .first_start_y(first_start_y),
        .first_end_x(first_end_x), .first_end_y(first_end_y),
        .second_start_x(second_start_x), .second_start_y(second_start_y),
        .second_end_x(second_end_x), .second_end_y(second_end_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit_valid(hit_valid), .cross_x(cross_x), .cross_y(cross_y), .clipped(clipped)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic send_pair(int ax, int ay, int bx, int by, int cx, int cy, int ex, int ey);
        first_start_x <= coord_t'(ax);
        first_start_y <= coord_t'(ay);
        first_end_x <= coord_t'(bx);
        first_end_y <= coord_t'(by);
        second_start_x <= coord_t'(cx);
        second_start_y <= coord_t'(cy);
        second_end_x <= coord_t'(ex);
        second_end_y <= coord_t'(ey);
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
                           coord_t'(cx), coord_t'(cy), coord_t'(ex), coord_t'(ey));
        if (!quiet && $urandom_range(0, 99) < 24) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // two short random segments, each around its own random anchor
    task automatic send_local_pair();
        int ax, ay, cx, cy;
        ax = $urandom_range(0, 4095);
        ay = $urandom_range(0, 4095);
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        send_pair(ax, ay, (ax + $urandom_range(0, 15)) % 4096,
                  (ay + $urandom_range(0, 15)) % 4096,
                  cx, cy, (cx + $urandom_range(0, 15)) % 4096,
                  (cy + $urandom_range(0, 15)) % 4096);
    endtask

    // drop the request line, then hold until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // receiver: sample the handshake, then pick the next ready
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result(hit_valid, cross_x, cross_y, clipped);
            out_ready <= quiet || ($urandom_range(0, 99) >= 24);
        end
    end

    initial
    begin
        #2000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(0, 0, 0, 0, 0, 0, 0, 0);                   // degenerate, det zero
        send_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        send_pair(0, 0, 4095, 0, 0, 0, 0, 4095);             // perpendicular, dot zero
        send_pair(0, 4095, 4095, 4095, 4095, 0, 4095, 4095);
        send_pair(0, 0, 4095, 4095, 0, 4095, 4095, 0);       // diagonals cross at center
        send_pair(0, 0, 100, 0, 0, 10, 100, 11);             // shallow angle, rejected
        send_pair(0, 0, 100, 0, 0, 0, 100, 100);             // exactly 45 degrees
        send_pair(0, 0, 100, 0, 5, 3, 105, 103);
        send_pair(0, 0, 100, 0, 0, 0, 100, 99);              // just under 45 degrees
        send_pair(10, 0, 0, 10, 0, 100, 1, 101);             // crossing at negative x
        send_pair(0, 0, 1, 0, 0, 1, 1, 1);                   // parallel
        send_pair(0, 0, 3, 7, 1, 0, 0, 3);                   // fractional result
        send_pair(4095, 0, 0, 4095, 0, 0, 1, 2);
        send_pair(1, 2, 4094, 2, 3, 4095, 7, 0);
        send_pair(2730, 1365, 1365, 2730, 0, 0, 4095, 4095);
        send_pair(4095, 4095, 4094, 4093, 0, 4095, 1, 4093); // crossing at y = 0, far from both segments
        send_pair(0, 4095, 4095, 0, 4095, 4095, 4094, 4094);
        wait_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            quiet <= (n >= 400 && n < 550);
            if ($urandom_range(0, 2) == 0)
                send_local_pair();
            else
                send_pair($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
        end
        in_valid <= 1'b0;
        quiet <= 1'b0;
        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("Checked %0d hits (%0d saturated) and %0d rejected pairs.",
                 board.hits, board.clips, board.misses);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
